/* src/ptrd_pkg.sv */
// ----------------------------------------------------------------------------
// ptrd_pkg: shared types and constants of the trigger register device
// Holds the request and result records, operation codes, register map and
// the LED timing constants used by the back end.
// ----------------------------------------------------------------------------
package ptrd_pkg;

  // Register file geometry
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = $clog2(NUM_REGS);

  // Register map
  localparam logic [7:0] ADDR_WAKE     = 8'd0;
  localparam logic [7:0] ADDR_WOKEN    = 8'd1;
  localparam logic [7:0] ADDR_ARM      = 8'd2;
  localparam logic [7:0] ADDR_CHANNELS = 8'd3;
  localparam logic [7:0] ADDR_FIRED    = 8'd4;

  // Operation codes on the op input
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CMD_ON   = 2'd0;
  localparam logic [1:0] CFG_CMD_OFF  = 2'd1;
  localparam logic [1:0] CFG_FIRE_MIN = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  CMD_ON_RST   = 8'd1;
  localparam logic [7:0]  CMD_OFF_RST  = 8'd0;
  localparam logic [15:0] FIRE_MIN_RST = 16'd250;

  // LED timing in ms
  localparam logic [15:0] TIME_MAX        = 16'hFFFF;
  localparam logic [15:0] LED_ON_MAX      = 16'd50;
  localparam logic [15:0] LED_FIRED_SHORT = 16'd50;
  localparam logic [15:0] LED_FIRED_LONG  = 16'd850;
  localparam logic [15:0] LED_ARMED_OFF   = 16'd450;
  localparam logic [15:0] LED_IDLE_OFF    = 16'd950;

  // Classified request kind
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_TICK,
    KIND_NOP
  } kind_t;

  // Request as handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        idx_ok;     // index inside the register file
    logic        read_only;  // write target is a status register
    logic [7:0]  idx;
    logic [31:0] data;
    logic [15:0] dt;
  } cmd_t;

  // Result record
  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_access;
    logic [2:0]  fire;
    logic        led;
    logic        fired;
    logic        awake;
  } result_t;

  // Add two millisecond counts, saturating at the counter maximum
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? TIME_MAX : s[15:0];
  endfunction

endpackage

/* src/ptrd_front.sv */
// ----------------------------------------------------------------------------
// ptrd_front: request intake and classification
// Accepts requests, sorts them by kind, checks the index and holds them in
// a two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module ptrd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        op,
  input  logic [7:0]        reg_index,
  input  logic [31:0]       write_data,
  input  logic [15:0]       delta_ms,
  output logic              cmd_valid,
  output ptrd_pkg::cmd_t    cmd,
  input  logic              cmd_take
);
  import ptrd_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       do_push;
  logic       do_pop;

  // Classify the incoming request
  always_comb begin
    cls.idx       = reg_index;
    cls.data      = write_data;
    cls.dt        = delta_ms;
    cls.idx_ok    = ({24'd0, reg_index} < NUM_REGS);
    cls.read_only = (reg_index == ADDR_WOKEN) || (reg_index == ADDR_FIRED);
    case (op)
      OP_WRITE: cls.kind = KIND_WRITE;
      OP_READ:  cls.kind = KIND_READ;
      OP_TICK:  cls.kind = KIND_TICK;
      default:  cls.kind = KIND_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Store the classified request
  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= cls;
  end

endmodule

/* src/ptrd_back.sv */
// ----------------------------------------------------------------------------
// ptrd_back: request execution
// Owns the register file, configuration, channel and LED timers. Carries out
// one request per cycle while the result queue is not full and emits its result record.
// ----------------------------------------------------------------------------
module ptrd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              cmd_valid,
  input  ptrd_pkg::cmd_t    cmd,
  output logic              cmd_take,
  output logic              res_push,
  output ptrd_pkg::result_t res,
  input  logic              res_full
);
  import ptrd_pkg::*;

  logic [7:0]  cmd_on;
  logic [7:0]  cmd_off;
  logic [15:0] fire_min_ms;

  logic [31:0] reg_file [NUM_REGS];
  logic [31:0] reg_file_next [NUM_REGS];
  logic [7:0]  last_index, last_index_next;
  logic        is_awake, is_awake_next;
  logic        is_fired, is_fired_next;
  logic [15:0] chan_ms [3];
  logic [15:0] chan_ms_next [3];
  logic [2:0]  chan_drive, chan_drive_next;
  logic        led_level, led_level_next;
  logic [15:0] led_on_time, led_on_time_next;
  logic [15:0] led_off_time, led_off_time_next;
  logic        short_gap, short_gap_next;

  logic [31:0] on32, off32;
  logic        arm_on, over, fired_mode, match;
  logic [15:0] ms_new, on_acc, off_acc, off_limit;
  logic [31:0] fired_val;
  logic [31:0] rd;
  logic        bad;

  assign cmd_take = cmd_valid && !res_full;
  assign res_push = cmd_take;
  assign on32     = {24'd0, cmd_on};
  assign off32    = {24'd0, cmd_off};

  // Work out the state after the request at the queue head
  always_comb begin
    reg_file_next     = reg_file;
    last_index_next   = last_index;
    is_awake_next     = is_awake;
    is_fired_next     = is_fired;
    chan_ms_next      = chan_ms;
    chan_drive_next   = chan_drive;
    led_level_next    = led_level;
    led_on_time_next  = led_on_time;
    led_off_time_next = led_off_time;
    short_gap_next    = short_gap;
    rd                = 32'd0;
    bad               = 1'b0;
    arm_on     = (reg_file[ADDR_ARM[IDX_W-1:0]] == on32);
    over       = 1'b0;
    match      = 1'b0;
    ms_new     = 16'd0;
    fired_val  = reg_file[ADDR_FIRED[IDX_W-1:0]];
    fired_mode = 1'b0;
    on_acc     = led_on_time;
    off_acc    = led_off_time;
    off_limit  = LED_IDLE_OFF;

    case (cmd.kind)
      KIND_WRITE: begin
        last_index_next = cmd.idx;
        if (!cmd.idx_ok || cmd.read_only) begin
          bad = 1'b1;
        end else begin
          reg_file_next[cmd.idx[IDX_W-1:0]] = cmd.data;
          if (cmd.idx == ADDR_WAKE && cmd.data == on32 && !is_awake) begin
            is_awake_next = 1'b1;
            reg_file_next[ADDR_WOKEN[IDX_W-1:0]] = on32;
          end
        end
      end
      KIND_READ: begin
        if (!cmd.idx_ok) bad = 1'b1;
        else             rd  = reg_file[cmd.idx[IDX_W-1:0]];
      end
      KIND_TICK: begin
        if (is_awake) begin
          // Drive channels from their byte fields while armed
          if (arm_on) begin
            for (int k = 0; k < 3; k++) begin
              match  = (reg_file[ADDR_CHANNELS[IDX_W-1:0]][8*k +: 8] == cmd_on);
              ms_new = match ? sat_add(chan_ms[k], cmd.dt) : 16'd0;
              chan_drive_next[k] = match;
              chan_ms_next[k]    = ms_new;
              if (ms_new > fire_min_ms) over = 1'b1;
            end
            if (over) begin
              is_fired_next = 1'b1;
              fired_val     = on32;
              reg_file_next[ADDR_FIRED[IDX_W-1:0]] = on32;
            end
          end
          // Blink the LED
          if (led_level) on_acc  = sat_add(led_on_time, cmd.dt);
          else           off_acc = sat_add(led_off_time, cmd.dt);
          if (fired_val == on32) begin
            fired_mode = 1'b1;
            off_limit  = short_gap ? LED_FIRED_SHORT : LED_FIRED_LONG;
          end else if (arm_on) begin
            off_limit  = LED_ARMED_OFF;
          end
          led_on_time_next  = on_acc;
          led_off_time_next = off_acc;
          if (on_acc > LED_ON_MAX) begin
            led_level_next   = 1'b0;
            led_on_time_next = 16'd0;
          end else if (off_acc > off_limit) begin
            led_level_next    = 1'b1;
            led_off_time_next = 16'd0;
            if (fired_mode) short_gap_next = !short_gap;
          end
          // Drop back to sleep on an off command in the wake register
          if (last_index == ADDR_WAKE && reg_file[ADDR_WAKE[IDX_W-1:0]] == off32) begin
            is_awake_next = 1'b0;
            reg_file_next[ADDR_WOKEN[IDX_W-1:0]] = off32;
          end
        end
      end
      default: begin
      end
    endcase

    res.read_data  = rd;
    res.bad_access = bad;
    res.fire       = chan_drive_next;
    res.led        = led_level_next;
    res.fired      = is_fired_next;
    res.awake      = is_awake_next;
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_on      <= CMD_ON_RST;
      cmd_off     <= CMD_OFF_RST;
      fire_min_ms <= FIRE_MIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CMD_ON:   cmd_on      <= cfg_data[7:0];
        CFG_CMD_OFF:  cmd_off     <= cfg_data[7:0];
        CFG_FIRE_MIN: fire_min_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Commit state on each executed request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) reg_file[i] <= 32'd0;
      for (int k = 0; k < 3; k++) chan_ms[k] <= 16'd0;
      last_index   <= 8'd0;
      is_awake     <= 1'b0;
      is_fired     <= 1'b0;
      chan_drive   <= 3'd0;
      led_level    <= 1'b0;
      led_on_time  <= 16'd0;
      led_off_time <= 16'd0;
      short_gap    <= 1'b0;
    end else if (cmd_take) begin
      reg_file     <= reg_file_next;
      chan_ms      <= chan_ms_next;
      last_index   <= last_index_next;
      is_awake     <= is_awake_next;
      is_fired     <= is_fired_next;
      chan_drive   <= chan_drive_next;
      led_level    <= led_level_next;
      led_on_time  <= led_on_time_next;
      led_off_time <= led_off_time_next;
      short_gap    <= short_gap_next;
    end
  end

endmodule

/* src/ptrd_result_queue.sv */
// ----------------------------------------------------------------------------
// ptrd_result_queue: result buffer
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module ptrd_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  ptrd_pkg::result_t res,
  output logic              res_full,
  output logic              empty,
  input  logic              pop,
  output ptrd_pkg::result_t head
);
  import ptrd_pkg::*;

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = slot[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= res;
  end

endmodule

/* src/pyro_trigger_register_device.sv */
// ----------------------------------------------------------------------------
// pyro_trigger_register_device: register-mapped trigger board
// Path: a request is registered in the front queue, then executed and its result
// registered in the result queue, whose head drives the result ports.
// Throughput: one request per cycle while the result queue is not full, set by the combinational execute stage.
// Reset: synchronous; clears the queues, register file, timers and flags and
// restores cmd_on to 1, cmd_off to 0 and fire_min_ms to 250.
// ----------------------------------------------------------------------------
module pyro_trigger_register_device (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [7:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [15:0] delta_ms,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] read_data,
  output logic        bad_access,
  output logic        fire1,
  output logic        fire2,
  output logic        fire3,
  output logic        led,
  output logic        fired,
  output logic        awake,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ptrd_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_take;
  logic    res_push;
  result_t res;
  logic    res_full;
  result_t head;

  // Accept and classify requests
  ptrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .reg_index  (reg_index),
    .write_data (write_data),
    .delta_ms   (delta_ms),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // Execute requests
  ptrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // Buffer results
  ptrd_result_queue u_results (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign read_data  = head.read_data;
  assign bad_access = head.bad_access;
  assign fire1      = head.fire[0];
  assign fire2      = head.fire[1];
  assign fire3      = head.fire[2];
  assign led        = head.led;
  assign fired      = head.fired;
  assign awake      = head.awake;

endmodule
